// ----- hdl/pspe_pkg.sv -----
// Shared types, constants and helper functions for the Pauli string product engine.
`timescale 1ns / 1ps

package pspe_pkg;

	// Qubits per string and the width of the active-qubit register.
	localparam int unsigned QW       = 64;
	localparam int unsigned AQ_W     = 7;
	localparam logic [AQ_W-1:0] AQ_RESET = 7'd64;

	// Command codes on the command port.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_MUL   = 2'd2
	} cmd_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// Table read issued by the sequencer, travels with the read data.
	typedef struct packed {
		logic valid;
		logic last;
	} issue_t;

	// Population count modulo four: eight byte counts, then their sum.
	function automatic logic [1:0] pop_mod4(input logic [QW-1:0] v);
		logic [1:0] grp;
		logic [1:0] acc;
		acc = 2'd0;
		for (int g = 0; g < QW / 8; g++) begin
			grp = 2'd0;
			for (int b = 0; b < 8; b++) begin
				grp = grp + {1'b0, v[g*8+b]};
			end
			acc = acc + grp;
		end
		return acc;
	endfunction

	// Mask with ones at bit positions below the active qubit count.
	function automatic logic [QW-1:0] qubit_mask(input logic [AQ_W-1:0] aq);
		logic [QW-1:0] m;
		for (int i = 0; i < QW; i++) begin
			m[i] = (AQ_W'(i) < aq);
		end
		return m;
	endfunction

endpackage

// ----- hdl/pauli_string_product_engine.sv -----
// Top level of the Pauli string product engine: ports, registers, table RAM.
//
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------------------
// command  | start / busy            | command, x_bits, z_bits, coeff_real, coeff_imag
// config   | cfg_valid / cfg_ready   | cfg_data (active_qubits)
// result   | prod_valid strobe       | prod_x, prod_z, phase, prod_real, prod_imag,
//          |                         | saturated, last
//
// Clear and load commands leave busy low.
// A multiply over N stored terms holds busy for its sweep, one table read per cycle
// from the single RAM read port, then while the product pipeline drains; the first product
// leaves the stage 5 output register and the rest follow on consecutive cycles.
// Reset leaves the table empty and active_qubits at 64; no clearing pass is needed.
// Results cannot be stalled; cfg_ready is always high.
`timescale 1ns / 1ps

module pauli_string_product_engine #(
	parameter int unsigned TABLE_DEPTH = 64,
	parameter int unsigned COEFF_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    command,
	input  logic [pspe_pkg::QW-1:0]       x_bits,
	input  logic [pspe_pkg::QW-1:0]       z_bits,
	input  logic signed [COEFF_WIDTH-1:0] coeff_real,
	input  logic signed [COEFF_WIDTH-1:0] coeff_imag,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pspe_pkg::AQ_W-1:0]     cfg_data,
	output logic                          prod_valid,
	output logic [pspe_pkg::QW-1:0]       prod_x,
	output logic [pspe_pkg::QW-1:0]       prod_z,
	output logic [1:0]                    phase,
	output logic signed [COEFF_WIDTH-1:0] prod_real,
	output logic signed [COEFF_WIDTH-1:0] prod_imag,
	output logic                          saturated,
	output logic                          last
);
	import pspe_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned RW = 2 * QW + 2 * COEFF_WIDTH + 2;

	logic [AQ_W-1:0]               aq_q;
	logic [QW-1:0]                 mask, mx, mz;
	logic [1:0]                    ypar;
	logic [QW-1:0]                 lhs_x_q, lhs_z_q;
	logic signed [COEFF_WIDTH-1:0] lhs_real_q, lhs_imag_q;
	logic [1:0]                    lhs_y_q;
	logic                          pipe_busy, wr_en, lhs_load;
	logic [AW-1:0]                 wr_addr, rd_addr;
	issue_t                        issue;
	logic [RW-1:0]                 wr_data, rd_data;

	// Active qubit register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aq_q <= AQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			aq_q <= cfg_data;
		end
	end

	// Masked input term and its Y count modulo four.
	assign mask    = qubit_mask(aq_q);
	assign mx      = x_bits & mask;
	assign mz      = z_bits & mask;
	assign ypar    = pop_mod4(mx & mz);
	assign wr_data = {ypar, coeff_imag, coeff_real, mz, mx};

	// Left-hand term held for the duration of a multiply.
	always_ff @(posedge clk) begin
		if (lhs_load) begin
			lhs_x_q    <= mx;
			lhs_z_q    <= mz;
			lhs_real_q <= coeff_real;
			lhs_imag_q <= coeff_imag;
			lhs_y_q    <= ypar;
		end
	end

	pspe_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.pipe_busy (pipe_busy),
		.busy      (busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.issue     (issue),
		.lhs_load  (lhs_load)
	);

	pspe_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue.valid),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pspe_datapath #(
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.rd_data    (rd_data),
		.lhs_x      (lhs_x_q),
		.lhs_z      (lhs_z_q),
		.lhs_real   (lhs_real_q),
		.lhs_imag   (lhs_imag_q),
		.lhs_y      (lhs_y_q),
		.pipe_busy  (pipe_busy),
		.prod_valid (prod_valid),
		.prod_x     (prod_x),
		.prod_z     (prod_z),
		.phase      (phase),
		.prod_real  (prod_real),
		.prod_imag  (prod_imag),
		.saturated  (saturated),
		.last       (last)
	);

endmodule

// ----- hdl/pspe_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pspe_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/pspe_seq.sv -----
// Command sequencer: entry count, table writes and the read sweep of a multiply.
`timescale 1ns / 1ps

module pspe_seq #(
	parameter int unsigned TABLE_DEPTH = 64,
	localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       command,
	input  logic             pipe_busy,
	output logic             busy,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [AW-1:0]    rd_addr,
	output pspe_pkg::issue_t issue,
	output logic             lhs_load
);
	import pspe_pkg::*;

	state_t          state_q, state_d;
	logic [CNTW-1:0] count_q;
	logic [CNTW-1:0] rd_q;
	logic            accept;
	logic            sweep_end;

	assign accept    = start && !busy;
	assign sweep_end = (rd_q + CNTW'(1)) == count_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && command == CMD_MUL && count_q != '0) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sweep_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs decoded from the state.
	always_comb begin
		busy        = (state_q != ST_IDLE);
		issue.valid = (state_q == ST_RUN);
		issue.last  = (state_q == ST_RUN) && sweep_end;
	end

	assign wr_en    = accept && command == CMD_LOAD && count_q < CNTW'(TABLE_DEPTH);
	assign wr_addr  = count_q[AW-1:0];
	assign rd_addr  = rd_q[AW-1:0];
	assign lhs_load = accept && command == CMD_MUL;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Entry count: cleared by a clear, advanced by a load into a table with room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && command == CMD_CLEAR) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNTW'(1);
		end
	end

	// Read index of the sweep, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
		end else if (lhs_load) begin
			rd_q <= '0;
		end else if (state_q == ST_RUN) begin
			rd_q <= rd_q + CNTW'(1);
		end
	end

`ifndef SYNTHESIS
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rd_q < count_q))
		else $error("read index beyond entry count");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(TABLE_DEPTH))
		else $error("entry count above table depth");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en)
		else $error("table written during a multiply sweep");
`endif

endmodule

// ----- hdl/pspe_datapath.sv -----
// Product datapath: bits and phase, complex multiply, phase rotation, rounding.
`timescale 1ns / 1ps

module pspe_datapath #(
	parameter int unsigned COEFF_WIDTH = 32,
	localparam int unsigned RW = 2 * pspe_pkg::QW + 2 * COEFF_WIDTH + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pspe_pkg::issue_t              issue,
	input  logic [RW-1:0]                 rd_data,
	input  logic [pspe_pkg::QW-1:0]       lhs_x,
	input  logic [pspe_pkg::QW-1:0]       lhs_z,
	input  logic signed [COEFF_WIDTH-1:0] lhs_real,
	input  logic signed [COEFF_WIDTH-1:0] lhs_imag,
	input  logic [1:0]                    lhs_y,
	output logic                          pipe_busy,
	output logic                          prod_valid,
	output logic [pspe_pkg::QW-1:0]       prod_x,
	output logic [pspe_pkg::QW-1:0]       prod_z,
	output logic [1:0]                    phase,
	output logic signed [COEFF_WIDTH-1:0] prod_real,
	output logic signed [COEFF_WIDTH-1:0] prod_imag,
	output logic                          saturated,
	output logic                          last
);
	import pspe_pkg::*;

	localparam int unsigned CW   = COEFF_WIDTH;
	localparam int unsigned FRAC = CW - 5;
	localparam int unsigned MW   = 2 * CW;
	localparam int unsigned PW   = 2 * CW + 2;
	localparam logic signed [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC - 1);
	localparam logic signed [PW-1:0] MAXV = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [PW-1:0] MINV = ~MAXV;

	// Round half up to FRAC fraction bits, then saturate; MSB is the saturation flag.
	function automatic logic [CW:0] round_sat(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		logic signed [PW-1:0] sh;
		logic [CW:0]          r;
		t  = v + HALF;
		sh = t >>> FRAC;
		if (sh > MAXV) begin
			r = {1'b1, MAXV[CW-1:0]};
		end else if (sh < MINV) begin
			r = {1'b1, MINV[CW-1:0]};
		end else begin
			r = {1'b0, sh[CW-1:0]};
		end
		return r;
	endfunction

	// Stage 1: fields of the stored term, straight from the RAM read register.
	logic                 valid_s1, last_s1;
	logic [QW-1:0]        rx, rz, ox, oz;
	logic signed [CW-1:0] rr, ri;
	logic [1:0]           ry, lxrz, ph_c;
	logic signed [MW-1:0] prr_c, pii_c, pri_c, pir_c;

	assign rx = rd_data[QW-1:0];
	assign rz = rd_data[2*QW-1:QW];
	assign rr = rd_data[2*QW+CW-1:2*QW];
	assign ri = rd_data[2*QW+2*CW-1:2*QW+CW];
	assign ry = rd_data[RW-1:RW-2];
	assign ox = lhs_x ^ rx;
	assign oz = lhs_z ^ rz;

	// Phase: Y count of the product minus both operand Y counts, plus twice the overlap of left X with right Z.
	assign lxrz = pop_mod4(lhs_x & rz);
	assign ph_c = pop_mod4(ox & oz) - lhs_y - ry + {lxrz[0], 1'b0};

	// Four partial products of the complex multiply.
	assign prr_c = lhs_real * rr;
	assign pii_c = lhs_imag * ri;
	assign pri_c = lhs_real * ri;
	assign pir_c = lhs_imag * rr;

	// Stage 2: registered products.
	logic                 valid_s2, last_s2;
	logic [QW-1:0]        x_s2, z_s2;
	logic [1:0]           ph_s2;
	logic signed [MW-1:0] prr_s2, pii_s2, pri_s2, pir_s2;

	// Stage 3: real and imaginary sums.
	logic                 valid_s3, last_s3;
	logic [QW-1:0]        x_s3, z_s3;
	logic [1:0]           ph_s3;
	logic signed [PW-1:0] re_s3, im_s3;

	// Stage 4: parts rotated by the phase.
	logic                 valid_s4, last_s4;
	logic [QW-1:0]        x_s4, z_s4;
	logic [1:0]           ph_s4;
	logic signed [PW-1:0] fr_s4, fi_s4;
	logic signed [PW-1:0] fr_c, fi_c;

	// Stage 5: rounded output register.
	logic                 valid_s5, last_s5, sat_s5;
	logic [QW-1:0]        x_s5, z_s5;
	logic [1:0]           ph_s5;
	logic signed [CW-1:0] re_s5, im_s5;
	logic [CW:0]          rnd_r, rnd_i;

	// Multiplication by i to the power of the phase.
	always_comb begin
		unique case (ph_s3)
			2'd0: begin
				fr_c = re_s3;
				fi_c = im_s3;
			end
			2'd1: begin
				fr_c = -im_s3;
				fi_c = re_s3;
			end
			2'd2: begin
				fr_c = -re_s3;
				fi_c = -im_s3;
			end
			default: begin
				fr_c = im_s3;
				fi_c = -re_s3;
			end
		endcase
	end

	assign rnd_r = round_sat(fr_s4);
	assign rnd_i = round_sat(fi_s4);

	// Valid and last bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			valid_s3 <= 1'b0;
			last_s3  <= 1'b0;
			valid_s4 <= 1'b0;
			last_s4  <= 1'b0;
			valid_s5 <= 1'b0;
			last_s5  <= 1'b0;
		end else begin
			valid_s1 <= issue.valid;
			last_s1  <= issue.last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			valid_s3 <= valid_s2;
			last_s3  <= last_s2;
			valid_s4 <= valid_s3;
			last_s4  <= last_s3;
			valid_s5 <= valid_s4;
			last_s5  <= last_s4;
		end
	end

	// Payload registers of stages 2 to 5.
	always_ff @(posedge clk) begin
		x_s2   <= ox;
		z_s2   <= oz;
		ph_s2  <= ph_c;
		prr_s2 <= prr_c;
		pii_s2 <= pii_c;
		pri_s2 <= pri_c;
		pir_s2 <= pir_c;

		x_s3  <= x_s2;
		z_s3  <= z_s2;
		ph_s3 <= ph_s2;
		re_s3 <= PW'(prr_s2) - PW'(pii_s2);
		im_s3 <= PW'(pri_s2) + PW'(pir_s2);

		x_s4  <= x_s3;
		z_s4  <= z_s3;
		ph_s4 <= ph_s3;
		fr_s4 <= fr_c;
		fi_s4 <= fi_c;

		x_s5   <= x_s4;
		z_s5   <= z_s4;
		ph_s5  <= ph_s4;
		re_s5  <= rnd_r[CW-1:0];
		im_s5  <= rnd_i[CW-1:0];
		sat_s5 <= rnd_r[CW] | rnd_i[CW];
	end

	assign pipe_busy  = valid_s1 | valid_s2 | valid_s3 | valid_s4;
	assign prod_valid = valid_s5;
	assign prod_x     = x_s5;
	assign prod_z     = z_s5;
	assign phase      = ph_s5;
	assign prod_real  = re_s5;
	assign prod_imag  = im_s5;
	assign saturated  = sat_s5;
	assign last       = last_s5;

`ifndef SYNTHESIS
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_s5 |-> valid_s5)
		else $error("last marked on an empty output cycle");
	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> ##3 valid_s5)
		else $error("table read lost in the pipeline");
	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_s5 |=> !last_s5)
		else $error("two last products in a row");
`endif

endmodule
